// ----- rtl/fpp_pkg.sv -----
`default_nettype none

package fpp_pkg;

   // Item operation codes.
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_CONTROL_ENABLE  = 3'd0;
   localparam csr_index_type REG_TARGET_FPS      = 3'd1;
   localparam csr_index_type REG_FRAME_PERIOD_MS = 3'd2;
   localparam csr_index_type REG_GAIN_P          = 3'd3;
   localparam csr_index_type REG_GAIN_I          = 3'd4;
   localparam csr_index_type REG_GAIN_D          = 3'd5;

   localparam logic [9:0] TARGET_FPS_RESET      = 10'd60;
   localparam logic [9:0] FRAME_PERIOD_MS_RESET = 10'd16;

   localparam int unsigned WINDOW_MS_DEFAULT = 1000;
   localparam int unsigned US_PER_MS         = 1000;

   typedef struct packed {
      logic               control_enable;
      logic [9:0]         target_fps;
      logic [9:0]         frame_period_ms;
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] error_sum;
      logic signed [16:0] previous_error;
      logic signed [31:0] delay_value;
   } pid_state_type;

endpackage

`default_nettype wire

// ----- rtl/fpp_if.sv -----
`default_nettype none

interface fpp_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] now_ms;

   modport source (output valid, output op, output now_ms, input ready);
   modport sink   (input valid, input op, input now_ms, output ready);
endinterface

interface fpp_rsp_if;
   logic               valid;
   logic               ready;
   logic               render_ok;
   logic [15:0]        measured_fps;
   logic signed [31:0] delay_us;

   modport source (output valid, output render_ok, output measured_fps, output delay_us,
                   input ready);
   modport sink   (input valid, input render_ok, input measured_fps, input delay_us,
                   output ready);
endinterface

interface fpp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/frame_rate_pid_pacer.sv -----
// Frame-rate pacer with a PID loop on the extra per-frame delay.
// req_ch carries words of op (frame done or pacing query) and a millisecond time stamp.
// rsp_ch returns exactly one word per request: render_ok, measured_fps and delay_us.
// csr_ch writes the six configuration registers by index; it is always ready and should
// only be written while no request is in flight.
// A request is registered on acceptance, and its response is registered from it once the
// response register is empty or its word is being taken; rsp_ch.valid is driven by the
// response register.
// Throughput is one word per cycle while the receiver is ready: the state update, including
// the three gain multiplies of the PID step, is done combinationally between the two registers.
// The pacing query compares the negative delay magnitude against 1000 times the remaining
// wait, so no divider is needed.
// When the receiver stalls, the response register holds its word, the request register
// holds the next one, and req_ch.ready falls until the response is taken.
// Synchronous reset clears all state, restores the register defaults (target 60 fps,
// period 16 ms, control off, gains zero) and empties both registers.
`default_nettype none

module frame_rate_pid_pacer
   import fpp_pkg::*;
#(
   parameter int unsigned WINDOW_MS = WINDOW_MS_DEFAULT
) (
   input  wire  clock,
   input  wire  reset,
   fpp_req_if.sink   req_ch,
   fpp_rsp_if.source rsp_ch,
   fpp_csr_if.sink   csr_ch
);

   cfg_type cfg_ff, cfg_in;

   logic        item_vld_ff, item_vld_in;
   logic        item_op_ff;
   logic [31:0] item_now_ff;

   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [15:0]        rsp_fps_ff, rsp_fps_in;
   logic signed [31:0] rsp_dly_ff, rsp_dly_in;

   logic [31:0]   last_time_ff, last_time_in;
   logic [31:0]   window_start_ff, window_start_in;
   logic [15:0]   frame_count_ff, frame_count_in;
   logic [15:0]   fps_ff, fps_in;
   pid_state_type pid_ff, pid_in, pid_next;

   logic        advance;
   logic        req_take;
   logic        fire;
   logic [15:0] count_inc;
   logic        window_done;
   logic [31:0] elapsed;
   logic [9:0]  need_ms;
   logic [19:0] need_us;
   logic [31:0] delay_mag;
   logic        query_ok;

   // The response register can be loaded when empty or when its word leaves this cycle.
   assign advance  = !rsp_vld_ff || rsp_ch.ready;
   assign fire     = item_vld_ff && advance;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !item_vld_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.render_ok    = rsp_ok_ff;
   assign rsp_ch.measured_fps = rsp_fps_ff;
   assign rsp_ch.delay_us     = rsp_dly_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_CONTROL_ENABLE:  cfg_in.control_enable  = csr_ch.data[0];
            REG_TARGET_FPS:      cfg_in.target_fps      = csr_ch.data[9:0];
            REG_FRAME_PERIOD_MS: cfg_in.frame_period_ms = csr_ch.data[9:0];
            REG_GAIN_P:          cfg_in.gain_p          = $signed(csr_ch.data);
            REG_GAIN_I:          cfg_in.gain_i          = $signed(csr_ch.data);
            REG_GAIN_D:          cfg_in.gain_d          = $signed(csr_ch.data);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   fpp_pid u_pid (
      .cfg (cfg_ff),
      .fps (count_inc),
      .cur (pid_ff),
      .nxt (pid_next)
   );

   assign count_inc   = (frame_count_ff == 16'hFFFF) ? frame_count_ff : frame_count_ff + 16'd1;
   assign window_done = (item_now_ff - window_start_ff) >= 32'(WINDOW_MS);

   // A negative delay of magnitude m shortens the wait by floor(m/1000) ms, so the query
   // passes once the remaining wait in ms, times 1000, is no more than m. The remaining
   // wait is only used when the elapsed time is below the period, so ten bits hold it.
   assign elapsed   = item_now_ff - last_time_ff;
   assign need_ms   = cfg_ff.frame_period_ms - elapsed[9:0];
   assign need_us   = 20'(need_ms) * 20'(US_PER_MS);
   assign delay_mag = 32'd0 - pid_ff.delay_value;

   always_comb begin
      if (!cfg_ff.control_enable) begin
         query_ok = 1'b1;
      end else if (elapsed >= {22'd0, cfg_ff.frame_period_ms}) begin
         query_ok = 1'b1;
      end else begin
         query_ok = pid_ff.delay_value[31] && (delay_mag >= {12'd0, need_us});
      end
   end

   always_comb begin
      last_time_in    = last_time_ff;
      window_start_in = window_start_ff;
      frame_count_in  = frame_count_ff;
      fps_in          = fps_ff;
      pid_in          = pid_ff;
      rsp_ok_in       = 1'b0;
      if (fire) begin
         case (item_op_ff)
            OP_FRAME: begin
               frame_count_in = count_inc;
               last_time_in   = item_now_ff;
               if (window_done) begin
                  fps_in          = count_inc;
                  frame_count_in  = 16'd0;
                  window_start_in = item_now_ff;
                  if (cfg_ff.control_enable) begin
                     pid_in = pid_next;
                  end
               end
            end
            OP_QUERY: begin
               rsp_ok_in = query_ok;
            end
            default: rsp_ok_in = 1'b0;
         endcase
      end
      rsp_fps_in = fps_in;
      rsp_dly_in = pid_in.delay_value;
   end

   assign item_vld_in = req_take ? 1'b1 : (fire ? 1'b0 : item_vld_ff);
   assign rsp_vld_in  = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_enable  <= 1'b0;
         cfg_ff.target_fps      <= TARGET_FPS_RESET;
         cfg_ff.frame_period_ms <= FRAME_PERIOD_MS_RESET;
         cfg_ff.gain_p          <= 16'sd0;
         cfg_ff.gain_i          <= 16'sd0;
         cfg_ff.gain_d          <= 16'sd0;
         item_vld_ff            <= 1'b0;
         rsp_vld_ff             <= 1'b0;
         last_time_ff           <= 32'd0;
         window_start_ff        <= 32'd0;
         frame_count_ff         <= 16'd0;
         fps_ff                 <= 16'd0;
         pid_ff                 <= '0;
      end else begin
         cfg_ff          <= cfg_in;
         item_vld_ff     <= item_vld_in;
         rsp_vld_ff      <= rsp_vld_in;
         last_time_ff    <= last_time_in;
         window_start_ff <= window_start_in;
         frame_count_ff  <= frame_count_in;
         fps_ff          <= fps_in;
         pid_ff          <= pid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_op_ff  <= req_ch.op;
         item_now_ff <= req_ch.now_ms;
      end
      if (fire) begin
         rsp_ok_ff  <= rsp_ok_in;
         rsp_fps_ff <= rsp_fps_in;
         rsp_dly_ff <= rsp_dly_in;
      end
   end

`ifndef ASSERT_OFF
   a_frame_word_not_ok: assert property (@(posedge clock) disable iff (reset)
      fire && (item_op_ff == OP_FRAME) |=> rsp_vld_ff && !rsp_ok_ff)
      else $error("frame-done word produced render_ok");

   a_pid_idle_when_off: assert property (@(posedge clock) disable iff (reset)
      !cfg_ff.control_enable |=> $stable(pid_ff))
      else $error("PID state moved while control was disabled");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && !advance |=> item_vld_ff && $stable(item_now_ff) && $stable(item_op_ff))
      else $error("pending request lost or overwritten during a stall");

   a_count_cleared_on_latch: assert property (@(posedge clock) disable iff (reset)
      fire && (item_op_ff == OP_FRAME) && window_done |=> frame_count_ff == 16'd0)
      else $error("frame count not restarted at window end");
`endif

endmodule

`default_nettype wire

// ----- rtl/fpp_pid.sv -----
`default_nettype none

module fpp_pid
   import fpp_pkg::*;
(
   input  cfg_type        cfg,
   input  logic [15:0]    fps,
   input  pid_state_type  cur,
   output pid_state_type  nxt
);

   logic signed [16:0] err;
   logic signed [32:0] esum_wide;
   logic signed [31:0] esum_sat;
   logic signed [17:0] err_diff;
   logic signed [32:0] prod_p;
   logic signed [47:0] prod_i;
   logic signed [33:0] prod_d;
   logic signed [49:0] sum;
   logic signed [49:0] sum_adj;
   logic signed [41:0] step;
   logic signed [42:0] dly_wide;
   logic signed [31:0] dly_sat;

   assign err = $signed({1'b0, fps}) - $signed({7'b0, cfg.target_fps});

   assign esum_wide = 33'(cur.error_sum) + 33'(err);
   always_comb begin
      if (esum_wide[32] != esum_wide[31]) begin
         esum_sat = esum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         esum_sat = esum_wide[31:0];
      end
   end

   assign err_diff = 18'(err) - 18'(cur.previous_error);

   assign prod_p = 33'(cfg.gain_p) * 33'(err);
   assign prod_i = 48'(cfg.gain_i) * 48'(esum_sat);
   assign prod_d = 34'(cfg.gain_d) * 34'(err_diff);

   assign sum = 50'(prod_p) + 50'(prod_i) + 50'(prod_d);

   // Bias a negative sum before the shift so that the division by 256 rounds toward zero.
   assign sum_adj = sum + (sum[49] ? 50'sd255 : 50'sd0);
   assign step    = sum_adj[49:8];

   assign dly_wide = 43'(cur.delay_value) + 43'(step);
   always_comb begin
      if (dly_wide[42:31] != {12{dly_wide[42]}}) begin
         dly_sat = dly_wide[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         dly_sat = dly_wide[31:0];
      end
   end

   always_comb begin
      nxt.error_sum      = esum_sat;
      nxt.previous_error = err;
      nxt.delay_value    = dly_sat;
   end

endmodule

`default_nettype wire

// ----- test/frame_rate_pid_pacer_tb.sv -----
module frame_rate_pid_pacer_tb
   import fpp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
   } pacer_word_type;

   typedef struct packed {
      logic               render_ok;
      logic [15:0]        measured_fps;
      logic signed [31:0] delay_us;
   } pacer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   fpp_req_if req_ch ();
   fpp_rsp_if rsp_ch ();
   fpp_csr_if csr_ch ();

   frame_rate_pid_pacer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pacer_word_type   pending_words[$];
   pacer_result_type expected_results[$];

   int unsigned words_sent;
   int unsigned words_taken;
   int unsigned req_gap_left;
   int unsigned rsp_stall_left;
   int unsigned rsp_hold_left;
   int unsigned mismatch_count;
   bit          hold_done;
   bit          idle_on;
   logic [31:0] stim_now;

   // Shadow copy of the pacer's configuration and state.
   cfg_type       shadow_cfg;
   pid_state_type shadow_pid;
   logic [31:0]   shadow_last_frame;
   logic [31:0]   shadow_window_start;
   logic [15:0]   shadow_frame_count;
   logic [15:0]   shadow_fps;

   function automatic logic signed [31:0] clamp_s32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic void run_pid_step();
      longint err;
      longint err_delta;
      longint sum;
      err = longint'(shadow_fps) - longint'(shadow_cfg.target_fps);
      shadow_pid.error_sum = clamp_s32(longint'($signed(shadow_pid.error_sum)) + err);
      err_delta = err - longint'($signed(shadow_pid.previous_error));
      sum = longint'($signed(shadow_cfg.gain_p)) * err
          + longint'($signed(shadow_cfg.gain_i)) * longint'($signed(shadow_pid.error_sum))
          + longint'($signed(shadow_cfg.gain_d)) * err_delta;
      // Signed division truncates toward zero, as the sum of Q8.8 gain products requires.
      shadow_pid.delay_value = clamp_s32(longint'($signed(shadow_pid.delay_value)) + sum / 256);
      shadow_pid.previous_error = err[16:0];
   endfunction

   function automatic pacer_result_type predict_pacer_result(logic op, logic [31:0] now_ms);
      pacer_result_type res;
      longint           wait_ms;
      logic [31:0]      elapsed;
      logic [31:0]      since_window;
      res.render_ok = 1'b0;
      if (op == OP_FRAME) begin
         if (shadow_frame_count != 16'hFFFF) shadow_frame_count++;
         shadow_last_frame = now_ms;
         since_window = now_ms - shadow_window_start;
         if (since_window >= WINDOW_MS_DEFAULT) begin
            shadow_fps = shadow_frame_count;
            shadow_frame_count = '0;
            shadow_window_start = now_ms;
            if (shadow_cfg.control_enable) run_pid_step();
         end
      end else if (!shadow_cfg.control_enable) begin
         res.render_ok = 1'b1;
      end else begin
         wait_ms = longint'(shadow_cfg.frame_period_ms);
         elapsed = now_ms - shadow_last_frame;
         if ($signed(shadow_pid.delay_value) < 0)
            wait_ms += longint'($signed(shadow_pid.delay_value)) / longint'(US_PER_MS);
         res.render_ok = (wait_ms <= 0) || (longint'(elapsed) >= wait_ms);
      end
      res.measured_fps = shadow_fps;
      res.delay_us = shadow_pid.delay_value;
      return res;
   endfunction

   function automatic void apply_csr_write(csr_index_type idx, logic [15:0] data);
      case (idx)
         REG_CONTROL_ENABLE:  shadow_cfg.control_enable  = data[0];
         REG_TARGET_FPS:      shadow_cfg.target_fps      = data[9:0];
         REG_FRAME_PERIOD_MS: shadow_cfg.frame_period_ms = data[9:0];
         REG_GAIN_P:          shadow_cfg.gain_p          = data;
         REG_GAIN_I:          shadow_cfg.gain_i          = data;
         REG_GAIN_D:          shadow_cfg.gain_d          = data;
         default: ;
      endcase
   endfunction

   // Request driver: a new word is offered once the previous one has been taken.
   always @(negedge clock) begin
      pacer_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || words_taken == words_sent) begin
         if (req_gap_left > 0) begin
            req_ch.valid <= 1'b0;
            req_gap_left--;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_ch.op     <= w.op;
            req_ch.now_ms <= w.now_ms;
            req_ch.valid  <= 1'b1;
            words_sent++;
            if (idle_on && $urandom_range(0, 7) == 0) req_gap_left = $urandom_range(1, 10);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, plus one long hold-off early on so that the pacer
   // fills up and has to push back on its request side.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_left--;
      end else if (!hold_done && words_taken >= 100) begin
         rsp_ch.ready <= 1'b0;
         hold_done = 1'b1;
         rsp_hold_left = 79;
      end else if (rsp_stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left = $urandom_range(0, 9);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: register writes and accepted requests update the shadow state first, so an
   // expectation is always queued before its result can be checked.
   always @(posedge clock) begin
      pacer_result_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) apply_csr_write(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_pacer_result(req_ch.op, req_ch.now_ms));
            words_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result word arrived with nothing expected", $time);
            end else begin
               want = expected_results.pop_front();
               if (want.render_ok !== rsp_ch.render_ok ||
                   want.measured_fps !== rsp_ch.measured_fps ||
                   want.delay_us !== rsp_ch.delay_us) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: render_ok %0b/%0b measured_fps %0d/%0d delay_us %0d/%0d %s",
                              $time, want.render_ok, rsp_ch.render_ok, want.measured_fps,
                              rsp_ch.measured_fps, want.delay_us, rsp_ch.delay_us,
                              "(expected/actual)");
               end
            end
         end
      end
   end

   function automatic void queue_word(logic op, logic [31:0] now_ms);
      pacer_word_type w;
      w.op = op;
      w.now_ms = now_ms;
      pending_words.push_back(w);
   endfunction

   task automatic wait_until_drained();
      while (pending_words.size() != 0 || words_taken != words_sent ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   // Unused bits of the narrow registers carry random data; a write to an unused
   // index follows and must change nothing.
   task automatic load_settings(bit en, logic [9:0] target, logic [9:0] period,
                                logic [15:0] gp, logic [15:0] gi, logic [15:0] gd);
      write_csr(REG_CONTROL_ENABLE, {15'($urandom), en});
      write_csr(REG_TARGET_FPS, {6'($urandom), target});
      write_csr(REG_FRAME_PERIOD_MS, {6'($urandom), period});
      write_csr(REG_GAIN_P, gp);
      write_csr(REG_GAIN_I, gi);
      write_csr(REG_GAIN_D, gd);
      write_csr(csr_index_type'(REG_GAIN_D + 3'($urandom_range(1, 2))), 16'($urandom));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(0, 1024)) - 16'd512;
      endcase
   endfunction

   function automatic logic [9:0] pick_rate();
      case ($urandom_range(0, 5))
         0:       return 10'd0;
         1:       return 10'd1;
         2:       return 10'd1023;
         default: return 10'($urandom_range(1, 1000));
      endcase
   endfunction

   task automatic load_random_settings();
      load_settings($urandom_range(0, 3) != 0, pick_rate(), pick_rate(),
                    pick_gain(), pick_gain(), pick_gain());
   endtask

   // Mostly time-ordered traffic with random steps; a few words carry arbitrary or
   // backward time stamps.
   task automatic queue_random_stretch(int unsigned count);
      int unsigned step_max;
      int unsigned r;
      logic        op;
      step_max = $urandom_range(1, 250);
      repeat (count) begin
         r = $urandom_range(0, 99);
         op = ($urandom_range(0, 2) == 0) ? OP_FRAME : OP_QUERY;
         if (r < 6) begin
            queue_word(op, $urandom());
         end else if (r < 10) begin
            queue_word(op, stim_now - $urandom_range(0, 2000));
         end else begin
            stim_now += $urandom_range(0, step_max);
            queue_word(op, stim_now);
         end
      end
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.op     = OP_FRAME;
      req_ch.now_ms = '0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = REG_CONTROL_ENABLE;
      csr_ch.data   = '0;
      shadow_cfg = '{1'b0, TARGET_FPS_RESET, FRAME_PERIOD_MS_RESET, 16'sd0, 16'sd0, 16'sd0};
      shadow_pid = '0;
      shadow_last_frame   = '0;
      shadow_window_start = '0;
      shadow_frame_count  = '0;
      shadow_fps          = '0;
      idle_on = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset the pacer grants everything and runs no PID step.
      queue_word(OP_QUERY, 32'd0);
      queue_word(OP_FRAME, 32'd0);
      queue_word(OP_FRAME, 32'd999);
      queue_word(OP_FRAME, 32'd1000);
      queue_word(OP_QUERY, 32'hFFFF_FFFF);
      queue_word(OP_FRAME, 32'hFFFF_FFFF);
      wait_until_drained();

      // The window closes across the time wrap; queries sit either side of the wait.
      load_settings(1'b1, 10'd1000, 10'd1000, 16'h7FFF, 16'h8000, 16'h8000);
      queue_word(OP_FRAME, 32'd999);
      queue_word(OP_QUERY, 32'd999);
      queue_word(OP_QUERY, 32'd1998);
      queue_word(OP_QUERY, 32'd1999);
      queue_word(OP_QUERY, 32'd2000);
      wait_until_drained();

      // A zero target and period: the wait is zero and every query is granted.
      load_settings(1'b1, 10'd0, 10'd0, 16'h8000, 16'h0000, 16'h7FFF);
      queue_word(OP_FRAME, 32'd1999);
      queue_word(OP_QUERY, 32'd1999);
      queue_word(OP_QUERY, 32'hFFFF_0000);
      wait_until_drained();

      // One frame per window far below target drives the delay to its negative limit.
      stim_now = 32'd5000;
      load_settings(1'b1, 10'd1000, 10'd20, 16'h0000, 16'h7FFF, 16'h0000);
      repeat (260) begin
         stim_now += 1000;
         queue_word(OP_FRAME, stim_now);
         queue_word(OP_QUERY, stim_now + $urandom_range(0, 30));
      end
      wait_until_drained();

      // Flipping the integral gain swings the delay up to its positive limit.
      load_settings(1'b1, 10'd1000, 10'd20, 16'h8000, 16'h8000, 16'h7FFF);
      repeat (150) begin
         stim_now += 1000;
         queue_word(OP_FRAME, stim_now);
         queue_word(OP_QUERY, stim_now + $urandom_range(0, 30));
      end
      wait_until_drained();

      idle_on = 1'b1;
      for (int seg = 0; seg < 5; seg++) begin
         load_random_settings();
         if (seg == 2) stim_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         queue_random_stretch(200);
         wait_until_drained();
      end

      idle_on = 1'b0;
      load_random_settings();
      queue_random_stretch(70);
      wait_until_drained();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fpp_pkg.sv
rtl/fpp_if.sv
rtl/fpp_pid.sv
rtl/frame_rate_pid_pacer.sv
test/frame_rate_pid_pacer_tb.sv
